// ===== design/sce_pkg.sv =====
`timescale 1ns / 1ps

package sce_pkg;

  localparam int unsigned MAX_LITERALS = 64;
  localparam int unsigned NUM_LEVELS   = 256;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned LBD_W     = 7;
  localparam int unsigned POS_W     = $clog2(MAX_LITERALS);
  localparam int unsigned CNT_W     = $clog2(MAX_LITERALS + 2);
  localparam int unsigned LVL_IDX_W = $clog2(NUM_LEVELS);
  localparam int unsigned RANK_W    = 10;
  localparam int unsigned EPOCH_W   = 16;

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [LBD_W-1:0]     lbd_t;
  typedef logic [LVL_IDX_W-1:0] lvl_idx_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [EPOCH_W-1:0]   epoch_t;

  localparam rank_t  RANK_WORST      = '1;
  localparam rank_t  RANK_UNASSIGNED = rank_t'(256);
  localparam rank_t  RANK_FALSE_BASE = rank_t'(512);
  localparam cnt_t   CNT_MAX_LIT     = cnt_t'(MAX_LITERALS);
  localparam cnt_t   CNT_SAT         = cnt_t'(MAX_LITERALS + 1);
  localparam cnt_t   CNT_MIN_LEN     = cnt_t'(2);
  localparam lbd_t   LBD_SAT         = '1;
  localparam lbd_t   LBD_KEEP_MAX    = lbd_t'(2);
  localparam epoch_t EPOCH_FIRST     = epoch_t'(1);
  localparam epoch_t EPOCH_LAST      = '1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } seen_state_e;

  typedef struct packed {
    logic     en;
    lvl_idx_t idx;
  } seen_rd_t;

  typedef struct packed {
    logic     wr_en;
    lvl_idx_t idx;
    logic     clause_end;
  } seen_upd_t;

  typedef struct packed {
    logic busy;
    logic epoch_last;
    logic seen;
  } seen_sts_t;

endpackage

// ===== design/sce_if.sv =====
`timescale 1ns / 1ps

interface sce_lit_if;
  logic                  valid;
  logic                  ready;
  logic                  lit_assigned;
  logic                  lit_true;
  logic [sce_pkg::LEVEL_W-1:0] lit_level;
  logic [sce_pkg::LBD_W-1:0]   prior_lbd;
  logic                  last;

  modport source (output valid, lit_assigned, lit_true, lit_level, prior_lbd, last,
                  input ready);
  modport sink (input valid, lit_assigned, lit_true, lit_level, prior_lbd, last,
                output ready);
endinterface

interface sce_res_if;
  logic                      valid;
  logic                      ready;
  logic [sce_pkg::POS_W-1:0] first_watch;
  logic [sce_pkg::POS_W-1:0] second_watch;
  logic                      is_unit;
  logic                      is_satisfied;
  logic [sce_pkg::LBD_W-1:0] new_lbd;
  logic                      lbd_changed;
  logic                      length_error;

  modport source (output valid, first_watch, second_watch, is_unit, is_satisfied,
                  new_lbd, lbd_changed, length_error, input ready);
  modport sink (input valid, first_watch, second_watch, is_unit, is_satisfied,
                new_lbd, lbd_changed, length_error, output ready);
endinterface

// ===== design/sce_seen_store.sv =====
`timescale 1ns / 1ps

module sce_seen_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sce_pkg::seen_rd_t   rd_i,
  input  sce_pkg::seen_upd_t  upd_i,
  output sce_pkg::seen_sts_t  sts_o
);
  import sce_pkg::*;

  epoch_t      mem [NUM_LEVELS];
  epoch_t      rdata_q;
  lvl_idx_t    rd_idx_q;

  seen_state_e state_q, state_d;
  lvl_idx_t    clr_cnt_q, clr_cnt_d;
  epoch_t      epoch_q, epoch_d;
  logic        fwd_vld_q, fwd_vld_d;
  lvl_idx_t    fwd_idx_q, fwd_idx_d;
  epoch_t      fwd_epoch_q, fwd_epoch_d;

  logic        wr_en;
  lvl_idx_t    wr_idx;
  epoch_t      wr_data;
  epoch_t      cur_tag;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_i.en) begin
      rdata_q  <= mem[rd_i.idx];
      rd_idx_q <= rd_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= EPOCH_FIRST;
      fwd_vld_q   <= 1'b0;
      fwd_idx_q   <= '0;
      fwd_epoch_q <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      epoch_q     <= epoch_d;
      fwd_vld_q   <= fwd_vld_d;
      fwd_idx_q   <= fwd_idx_d;
      fwd_epoch_q <= fwd_epoch_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    epoch_d     = epoch_q;
    fwd_vld_d   = fwd_vld_q;
    fwd_idx_d   = fwd_idx_q;
    fwd_epoch_d = fwd_epoch_q;
    wr_en       = 1'b0;
    wr_idx      = upd_i.idx;
    wr_data     = epoch_q;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_idx    = clr_cnt_q;
        wr_data   = '0;
        fwd_vld_d = 1'b0;
        clr_cnt_d = clr_cnt_q + lvl_idx_t'(1);
        if (clr_cnt_q == lvl_idx_t'(NUM_LEVELS - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (upd_i.wr_en) begin
          wr_en       = 1'b1;
          fwd_vld_d   = 1'b1;
          fwd_idx_d   = upd_i.idx;
          fwd_epoch_d = epoch_q;
        end
        if (upd_i.clause_end) begin
          if (epoch_q == EPOCH_LAST) begin
            state_d   = ST_CLEAR;
            clr_cnt_d = '0;
            epoch_d   = EPOCH_FIRST;
          end else begin
            epoch_d = epoch_q + epoch_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // write from the item just ahead lands at the edge the read samples
  assign cur_tag = (fwd_vld_q && (fwd_idx_q == rd_idx_q)) ? fwd_epoch_q : rdata_q;

  assign sts_o.busy       = (state_q == ST_CLEAR);
  assign sts_o.epoch_last = (epoch_q == EPOCH_LAST);
  assign sts_o.seen       = (cur_tag == epoch_q);

endmodule

// ===== design/sat_clause_evaluator.sv =====
`timescale 1ns / 1ps
// The item marked last waits in stage 1 until the previous result is taken; the result
// is registered as it leaves. Seen levels are tagged with a clause epoch; every 65535
// clauses, and once after reset, a clearing pass sweeps the 256 entries and input is
// held off. Else one literal item per cycle (seen-level memory read/write loop).
// Reset: asynchronous active low; clears all counters, ranks and the result valid flag.
module sat_clause_evaluator (
  input  logic       clk_i,
  input  logic       rst_ni,
  sce_lit_if.sink    lit_i,
  sce_res_if.source  res_o
);
  import sce_pkg::*;

  function automatic cnt_t cnt_inc(cnt_t v);
    return (v < CNT_SAT) ? v + cnt_t'(1) : CNT_SAT;
  endfunction

  seen_rd_t  seen_rd;
  seen_upd_t seen_upd;
  seen_sts_t seen_sts;

  logic   lit_fire;
  logic   s1_fire;
  logic   out_free;

  logic   s1_valid_q, s1_valid_d;
  logic   s1_assigned_q;
  logic   s1_true_q;
  level_t s1_level_q;
  lbd_t   s1_prior_q;
  logic   s1_last_q;

  cnt_t   lit_cnt_q, lit_cnt_d, lit_cnt_u;
  cnt_t   false_cnt_q, false_cnt_d, false_cnt_u;
  cnt_t   unas_cnt_q, unas_cnt_d, unas_cnt_u;
  logic   any_true_q, any_true_d, any_true_u;
  lbd_t   lbd_cnt_q, lbd_cnt_d, lbd_cnt_u;
  rank_t  best_rank_q, best_rank_d, best_rank_u;
  pos_t   best_pos_q, best_pos_d, best_pos_u;
  rank_t  run_rank_q, run_rank_d, run_rank_u;
  pos_t   run_pos_q, run_pos_d, run_pos_u;
  rank_t  head_rank_q, head_rank_d, head_rank_u;

  logic   res_valid_q, res_valid_d;
  pos_t   fw_q, fw_d;
  pos_t   sw_q, sw_d;
  logic   unit_q, unit_d;
  logic   sat_q, sat_d;
  lbd_t   nlbd_q, nlbd_d;
  logic   chg_q, chg_d;
  logic   err_q, err_d;

  rank_t  rank;
  pos_t   pos;

  assign out_free = !res_valid_q || res_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_last_q || out_free);
  assign lit_i.ready = !seen_sts.busy
                    && !(s1_valid_q && s1_last_q && seen_sts.epoch_last)
                    && (!s1_valid_q || s1_fire);
  assign lit_fire = lit_i.valid && lit_i.ready;

  assign seen_rd.en  = lit_fire;
  assign seen_rd.idx = lit_i.lit_level[LVL_IDX_W-1:0];

  assign seen_upd.wr_en      = s1_fire && s1_assigned_q;
  assign seen_upd.idx        = s1_level_q[LVL_IDX_W-1:0];
  assign seen_upd.clause_end = s1_fire && s1_last_q;

  sce_seen_store u_seen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (seen_rd),
    .upd_i  (seen_upd),
    .sts_o  (seen_sts)
  );

  assign s1_valid_d = lit_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i) begin
    if (lit_fire) begin
      s1_assigned_q <= lit_i.lit_assigned;
      s1_true_q     <= lit_i.lit_true;
      s1_level_q    <= lit_i.lit_level;
      s1_prior_q    <= lit_i.prior_lbd;
      s1_last_q     <= lit_i.last;
    end
  end

  always_comb begin
    if (!s1_assigned_q) begin
      rank = RANK_UNASSIGNED;
    end else if (s1_true_q) begin
      rank = rank_t'(s1_level_q);
    end else begin
      rank = RANK_FALSE_BASE - rank_t'(s1_level_q);
    end
  end

  assign pos = lit_cnt_q[POS_W-1:0];

  always_comb begin
    best_rank_u = best_rank_q;
    best_pos_u  = best_pos_q;
    run_rank_u  = run_rank_q;
    run_pos_u   = run_pos_q;
    head_rank_u = head_rank_q;
    if (lit_cnt_q < CNT_MAX_LIT) begin
      priority if (lit_cnt_q == '0) begin
        head_rank_u = rank;
      end else if (rank < best_rank_q) begin
        run_rank_u  = best_rank_q;
        run_pos_u   = best_pos_q;
        best_rank_u = rank;
        best_pos_u  = pos;
      end else if (rank < run_rank_q) begin
        run_rank_u = rank;
        run_pos_u  = pos;
      end
    end

    lit_cnt_u   = cnt_inc(lit_cnt_q);
    false_cnt_u = false_cnt_q;
    unas_cnt_u  = unas_cnt_q;
    any_true_u  = any_true_q;
    lbd_cnt_u   = lbd_cnt_q;
    if (s1_assigned_q) begin
      if (s1_true_q) begin
        any_true_u = 1'b1;
      end else begin
        false_cnt_u = cnt_inc(false_cnt_q);
      end
      if ((s1_level_q != '0) && !seen_sts.seen && (lbd_cnt_q != LBD_SAT)) begin
        lbd_cnt_u = lbd_cnt_q + lbd_t'(1);
      end
    end else begin
      unas_cnt_u = cnt_inc(unas_cnt_q);
      if (lbd_cnt_q != LBD_SAT) begin
        lbd_cnt_u = lbd_cnt_q + lbd_t'(1);
      end
    end
  end

  always_comb begin
    lit_cnt_d   = lit_cnt_q;
    false_cnt_d = false_cnt_q;
    unas_cnt_d  = unas_cnt_q;
    any_true_d  = any_true_q;
    lbd_cnt_d   = lbd_cnt_q;
    best_rank_d = best_rank_q;
    best_pos_d  = best_pos_q;
    run_rank_d  = run_rank_q;
    run_pos_d   = run_pos_q;
    head_rank_d = head_rank_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        lit_cnt_d   = '0;
        false_cnt_d = '0;
        unas_cnt_d  = '0;
        any_true_d  = 1'b0;
        lbd_cnt_d   = '0;
        best_rank_d = RANK_WORST;
        best_pos_d  = '0;
        run_rank_d  = RANK_WORST;
        run_pos_d   = '0;
        head_rank_d = RANK_WORST;
      end else begin
        lit_cnt_d   = lit_cnt_u;
        false_cnt_d = false_cnt_u;
        unas_cnt_d  = unas_cnt_u;
        any_true_d  = any_true_u;
        lbd_cnt_d   = lbd_cnt_u;
        best_rank_d = best_rank_u;
        best_pos_d  = best_pos_u;
        run_rank_d  = run_rank_u;
        run_pos_d   = run_pos_u;
        head_rank_d = head_rank_u;
      end
    end
  end

  always_comb begin
    fw_d   = '0;
    sw_d   = '0;
    unit_d = 1'b0;
    sat_d  = 1'b0;
    nlbd_d = s1_prior_q;
    chg_d  = 1'b0;
    err_d  = 1'b0;
    if ((lit_cnt_u < CNT_MIN_LEN) || (lit_cnt_u > CNT_MAX_LIT)) begin
      err_d = 1'b1;
    end else begin
      if (head_rank_u <= best_rank_u) begin
        sw_d = best_pos_u;
      end else begin
        fw_d = best_pos_u;
        if ((head_rank_u < run_rank_u) ||
            ((head_rank_u == run_rank_u) && (best_pos_u < run_pos_u))) begin
          sw_d = '0;
        end else begin
          sw_d = run_pos_u;
        end
      end
      unit_d = (unas_cnt_u == cnt_t'(1)) && ((false_cnt_u + cnt_t'(1)) == lit_cnt_u);
      sat_d  = any_true_u;
      if ((s1_prior_q > LBD_KEEP_MAX) && (lbd_cnt_u < s1_prior_q)) begin
        nlbd_d = lbd_cnt_u;
      end
      chg_d = (nlbd_d != s1_prior_q);
    end
  end

  assign res_valid_d = seen_upd.clause_end ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i) begin
    if (seen_upd.clause_end) begin
      fw_q   <= fw_d;
      sw_q   <= sw_d;
      unit_q <= unit_d;
      sat_q  <= sat_d;
      nlbd_q <= nlbd_d;
      chg_q  <= chg_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      lit_cnt_q   <= '0;
      false_cnt_q <= '0;
      unas_cnt_q  <= '0;
      any_true_q  <= 1'b0;
      lbd_cnt_q   <= '0;
      best_rank_q <= RANK_WORST;
      best_pos_q  <= '0;
      run_rank_q  <= RANK_WORST;
      run_pos_q   <= '0;
      head_rank_q <= RANK_WORST;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      lit_cnt_q   <= lit_cnt_d;
      false_cnt_q <= false_cnt_d;
      unas_cnt_q  <= unas_cnt_d;
      any_true_q  <= any_true_d;
      lbd_cnt_q   <= lbd_cnt_d;
      best_rank_q <= best_rank_d;
      best_pos_q  <= best_pos_d;
      run_rank_q  <= run_rank_d;
      run_pos_q   <= run_pos_d;
      head_rank_q <= head_rank_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.first_watch  = fw_q;
  assign res_o.second_watch = sw_q;
  assign res_o.is_unit      = unit_q;
  assign res_o.is_satisfied = sat_q;
  assign res_o.new_lbd      = nlbd_q;
  assign res_o.lbd_changed  = chg_q;
  assign res_o.length_error = err_q;

endmodule

// ===== design/sce_checker.sv =====
`timescale 1ns / 1ps

module sce_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic [sce_pkg::POS_W-1:0] first_watch_i,
  input logic [sce_pkg::POS_W-1:0] second_watch_i,
  input logic                      is_unit_i,
  input logic                      is_satisfied_i,
  input logic [sce_pkg::LBD_W-1:0] new_lbd_i,
  input logic                      lbd_changed_i,
  input logic                      length_error_i
);
  import sce_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(first_watch_i)
      && $stable(second_watch_i) && $stable(new_lbd_i) && $stable(length_error_i))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && length_error_i |-> first_watch_i == '0 && second_watch_i == '0
      && !is_unit_i && !is_satisfied_i && !lbd_changed_i)
    else $error("length error result carries nonzero fields");

  a_unit_unsat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && is_unit_i |-> !is_satisfied_i)
    else $error("unit clause reported satisfied");

  a_watch_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !length_error_i |-> first_watch_i != second_watch_i)
    else $error("both watches on one literal");

endmodule

bind sat_clause_evaluator sce_checker u_sce_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .first_watch_i  (res_o.first_watch),
  .second_watch_i (res_o.second_watch),
  .is_unit_i      (res_o.is_unit),
  .is_satisfied_i (res_o.is_satisfied),
  .new_lbd_i      (res_o.new_lbd),
  .lbd_changed_i  (res_o.lbd_changed),
  .length_error_i (res_o.length_error)
);
